[rtl/core/ffha_pkg.sv]
// package: constants, types and codes of the first-fit heap allocator
`default_nettype none

package ffha_pkg;

  // heap geometry
  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned NWORDS       = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned WIDX_W       = $clog2(NWORDS);
  localparam int unsigned ALIGN_SH     = $clog2(ALIGN_BYTES);
  localparam int unsigned HDR_WORDS    = HEADER_BYTES / ALIGN_BYTES;
  localparam int unsigned MIN_HEAP     = HEADER_BYTES + ALIGN_BYTES;
  localparam int unsigned STEP_W       = WIDX_W + 1;

  // field widths
  localparam int unsigned HEAP_W = 17;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned OFF_W  = 16;

  typedef logic [WIDX_W-1:0] widx_t;
  typedef logic [SIZE_W-1:0] bsize_t;

  // link half of a block header
  typedef struct packed {
    logic  valid;
    widx_t next;
  } link_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_NULL_PTR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_SPLIT,
    S_LINK,
    S_CLEAR,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

[rtl/core/first_fit_heap_allocator_top.sv]
// top level: first-fit free-list heap allocator with header memories
`default_nettype none

// first-fit free-list allocator over a heap of 64 KiB, 8-byte words,
// 16-byte block headers kept in two on-chip memories (size and link)
// input channel (in_valid_i / in_ready_o) carries one item: opcode_i,
// request_bytes_i for allocate, data_offset_i for free
// output channel (out_valid_o / out_ready_i) returns one item per input:
// status_o and granted_offset_o
// cfg_we_i with cfg_wdata_i sets heap_size (clamped to 24..65536) and
// rebuilds the heap as one free block
// a null free, a bad size or an empty list goes straight to the result;
// a free pushes the block onto the list head; an allocate visits free
// blocks, one header read per cycle on the memory read port, then goes
// through S_SPLIT (only when it splits), S_LINK and S_CLEAR
// reset: heap_size returns to 65536 and a rebuild runs before
// the first item is taken; header memories themselves are not cleared
// a finished result sits in an internal result register until the output
// register is free; while it waits the block stays in its result state
// and accepts no new item
module first_fit_heap_allocator_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ffha_pkg::HEAP_W-1:0]   cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          opcode_i,
  input  wire [ffha_pkg::REQ_W-1:0]    request_bytes_i,
  input  wire [ffha_pkg::OFF_W-1:0]    data_offset_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [1:0]                   status_o,
  output logic [ffha_pkg::OFF_W-1:0]   granted_offset_o
);
  import ffha_pkg::*;

  // header memories: data size and next link per word
  bsize_t size_mem [NWORDS];
  link_t  link_mem [NWORDS];

  state_e               state_q, state_d;
  logic                 rebuild_q, rebuild_d;
  logic [HEAP_W-1:0]    heap_size_q, heap_size_d;
  link_t                head_q, head_d;
  logic                 out_valid_q, out_valid_d;

  // walk context
  widx_t                cur_q, cur_d;
  widx_t                prev_q, prev_d;
  logic                 has_prev_q, has_prev_d;
  logic [STEP_W-1:0]    steps_q, steps_d;
  bsize_t               need_q, need_d;
  bsize_t               csize_q, csize_d;
  link_t                nxt_q, nxt_d;
  logic                 split_q, split_d;

  // result waiting for the output register
  status_e              res_status_q, res_status_d;
  logic [OFF_W-1:0]     res_granted_q, res_granted_d;
  status_e              status_q, status_d;
  logic [OFF_W-1:0]     granted_q, granted_d;

  // memory ports
  logic                 rd_en;
  widx_t                rd_addr;
  bsize_t               size_rd_q;
  link_t                link_rd_q;
  logic                 size_we;
  widx_t                size_wa;
  bsize_t               size_wd;
  logic                 link_we;
  widx_t                link_wa;
  link_t                link_wd;

  // helpers
  logic [HEAP_W-1:0]    cfg_sat;
  bsize_t               need_calc;
  logic [OFF_W-1:0]     free_sub;
  widx_t                free_word;
  bsize_t               nb_sum;
  widx_t                nb;
  logic [OFF_W-1:0]     grant_calc;
  link_t                new_link;
  logic                 out_free;

  always_comb begin
    priority if (cfg_wdata_i < HEAP_W'(MIN_HEAP)) begin
      cfg_sat = HEAP_W'(MIN_HEAP);
    end else if (cfg_wdata_i > HEAP_W'(HEAP_BYTES)) begin
      cfg_sat = HEAP_W'(HEAP_BYTES);
    end else begin
      cfg_sat = cfg_wdata_i;
    end
  end

  // round request up to a whole word
  assign need_calc  = (SIZE_W'(request_bytes_i) + SIZE_W'(ALIGN_BYTES - 1))
                      & ~SIZE_W'(ALIGN_BYTES - 1);
  // header word of a freed block, subtraction wraps
  assign free_sub   = data_offset_i - OFF_W'(HEADER_BYTES);
  assign free_word  = free_sub[ALIGN_SH +: WIDX_W];
  // word of the split-off tail block
  assign nb_sum     = SIZE_W'(cur_q) + SIZE_W'(HDR_WORDS) + (need_q >> ALIGN_SH);
  assign nb         = nb_sum[WIDX_W-1:0];
  assign grant_calc = OFF_W'({cur_q, {ALIGN_SH{1'b0}}}) + OFF_W'(HEADER_BYTES);
  assign new_link   = split_q ? link_t'{valid: 1'b1, next: nb} : nxt_q;
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE) && !rebuild_q;

  always_comb begin
    state_d       = state_q;
    rebuild_d     = rebuild_q;
    heap_size_d   = heap_size_q;
    head_d        = head_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cur_d         = cur_q;
    prev_d        = prev_q;
    has_prev_d    = has_prev_q;
    steps_d       = steps_q;
    need_d        = need_q;
    csize_d       = csize_q;
    nxt_d         = nxt_q;
    split_d       = split_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    status_d      = status_q;
    granted_d     = granted_q;
    rd_en         = 1'b0;
    rd_addr       = link_rd_q.next;
    size_we       = 1'b0;
    size_wa       = cur_q;
    size_wd       = need_q;
    link_we       = 1'b0;
    link_wa       = cur_q;
    link_wd       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (rebuild_q) begin
          // whole heap becomes one free block at word 0
          size_we   = 1'b1;
          size_wa   = '0;
          size_wd   = SIZE_W'(heap_size_q - HEAP_W'(HEADER_BYTES));
          link_we   = 1'b1;
          link_wa   = '0;
          link_wd   = '0;
          head_d    = link_t'{valid: 1'b1, next: '0};
          rebuild_d = 1'b0;
        end else if (in_valid_i) begin
          res_granted_d = '0;
          state_d       = S_RESP;
          if (opcode_i == OP_FREE) begin
            if (data_offset_i == '0) begin
              res_status_d = ST_NULL_PTR;
            end else begin
              // push onto the list head
              res_status_d = ST_OK;
              link_we      = 1'b1;
              link_wa      = free_word;
              link_wd      = head_q;
              head_d       = link_t'{valid: 1'b1, next: free_word};
            end
          end else if (request_bytes_i == '0) begin
            res_status_d = ST_BAD_SIZE;
          end else if (!head_q.valid) begin
            res_status_d = ST_NO_FIT;
          end else begin
            need_d     = need_calc;
            has_prev_d = 1'b0;
            steps_d    = '0;
            cur_d      = head_q.next;
            rd_en      = 1'b1;
            rd_addr    = head_q.next;
            state_d    = S_WALK;
          end
        end
      end
      S_WALK: begin
        // header of cur_q is on the read port
        if (size_rd_q >= need_q) begin
          csize_d = size_rd_q;
          nxt_d   = link_rd_q;
          split_d = (size_rd_q - need_q) >= SIZE_W'(MIN_HEAP);
          state_d = ((size_rd_q - need_q) >= SIZE_W'(MIN_HEAP)) ? S_SPLIT : S_LINK;
        end else begin
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          steps_d    = steps_q + 1'b1;
          if (!link_rd_q.valid || (steps_q + 1'b1) == STEP_W'(NWORDS)) begin
            res_status_d  = ST_NO_FIT;
            res_granted_d = '0;
            state_d       = S_RESP;
          end else begin
            cur_d   = link_rd_q.next;
            rd_en   = 1'b1;
            rd_addr = link_rd_q.next;
          end
        end
      end
      S_SPLIT: begin
        // tail block takes over the found block's successor
        size_we = 1'b1;
        size_wa = nb;
        size_wd = csize_q - SIZE_W'(HEADER_BYTES) - need_q;
        link_we = 1'b1;
        link_wa = nb;
        link_wd = nxt_q;
        state_d = S_LINK;
      end
      S_LINK: begin
        if (split_q) begin
          size_we = 1'b1;
          size_wa = cur_q;
          size_wd = need_q;
        end
        if (has_prev_q) begin
          link_we = 1'b1;
          link_wa = prev_q;
          link_wd = new_link;
        end else begin
          head_d = new_link;
        end
        state_d = S_CLEAR;
      end
      S_CLEAR: begin
        link_we       = 1'b1;
        link_wa       = cur_q;
        link_wd       = '0;
        res_status_d  = ST_OK;
        res_granted_d = grant_calc;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          granted_d   = res_granted_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      heap_size_d = cfg_sat;
      rebuild_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rebuild_q   <= 1'b1;
      heap_size_q <= HEAP_W'(HEAP_BYTES);
      head_q      <= link_t'{valid: 1'b1, next: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rebuild_q   <= rebuild_d;
      heap_size_q <= heap_size_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    prev_q        <= prev_d;
    has_prev_q    <= has_prev_d;
    steps_q       <= steps_d;
    need_q        <= need_d;
    csize_q       <= csize_d;
    nxt_q         <= nxt_d;
    split_q       <= split_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    status_q      <= status_d;
    granted_q     <= granted_d;
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (rd_en) begin
      size_rd_q <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = granted_q;

  // failed items never carry an offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> granted_offset_o == '0)
    else $error("failed item with nonzero offset");

  // split tail never lands on the granted block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SPLIT |-> nb != cur_q)
    else $error("split tail overlaps granted header");

  // the walk is bounded by the number of words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> steps_q < STEP_W'(NWORDS))
    else $error("walk exceeded word count");

  // a rebuild leaves the head on word 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && rebuild_q && !cfg_we_i |=>
      head_q.valid && (head_q.next == '0))
    else $error("rebuild left head elsewhere");

  // output register only loads from the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("output loaded outside result state");

endmodule

`default_nettype wire
